>>> rtl/core/ssrl_pkg.sv
package ssrl_pkg;

	// Field widths of the item, result and configuration channels
	localparam int CH_W       = 2;
	localparam int ANG_W      = 8;
	localparam int SPD_W      = 10;
	localparam int NOW_W      = 32;
	localparam int PW_W       = 12;
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 8;

	// Parameter defaults
	localparam int NUM_CHANNELS_DEF = 4;
	localparam int TIME_BITS_DEF    = 32;

	// Channels that the two-bit channel field and the register list reach
	localparam int CFG_CHANNELS = 4;

	// Item codes
	typedef enum logic {
		CMD_SET  = 1'b0,
		CMD_TICK = 1'b1
	} cmd_t;

	// Sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_MUL,
		ST_QUO,
		ST_UPD
	} state_t;

	// Time difference is capped so the step product stays narrow
	localparam int              DT_W    = 18;
	localparam logic [DT_W-1:0] DT_CAP  = 18'd256000;
	localparam int              PROD_W  = SPD_W + DT_W;

	// Step saturation: floor(p/1000) > 255 iff p >= 256000, ceil > 255 iff p > 255000
	localparam logic [PROD_W-1:0] SAT_FLO = 28'd256000;
	localparam logic [PROD_W-1:0] SAT_CEI = 28'd255000;
	localparam logic [ANG_W-1:0]  STEP_CAP = 8'd255;

	// Divide by 1000 through a reciprocal, exact for dividends below 2^18
	localparam int                 DIVD_W      = 18;
	localparam int                 RECIP_W     = 19;
	localparam logic [RECIP_W-1:0] RECIP_1000  = 19'd268436;
	localparam int                 RECIP_SHIFT = 28;
	localparam int                 QUO_W       = 9;
	localparam logic [DIVD_W-1:0]  DIVISOR     = 18'd1000;

	// Pulse width: floor(a*95/9) = (a*95*ceil(2^18/9)) >> 18 for a below 256
	localparam int              PW_MUL_W  = 22;
	localparam logic [PW_MUL_W-1:0] PW_MUL = 22'd2767160;
	localparam int              PW_SHIFT  = 18;
	localparam logic [PW_W-1:0] PW_OFFSET = 12'd600;
	localparam logic [ANG_W-1:0] ANGLE_MAX = 8'd180;

	// Limits of the addressed channel
	typedef struct packed {
		logic [ANG_W-1:0] min_angle;
		logic [ANG_W-1:0] max_angle;
	} limits_t;

	// Stage enables handed to the step datapath
	typedef struct packed {
		logic mul_en;
		logic quo_en;
	} slew_ctl_t;

	function automatic logic [ANG_W-1:0] rst_min(input logic [1:0] ch);
		case (ch)
			2'd1:    return 8'd18;
			2'd2:    return 8'd15;
			default: return 8'd0;
		endcase
	endfunction

	function automatic logic [ANG_W-1:0] rst_max(input logic [1:0] ch);
		case (ch)
			2'd1:    return 8'd70;
			default: return 8'd180;
		endcase
	endfunction

	function automatic logic [ANG_W-1:0] rst_target(input logic [3:0] ch);
		case (ch)
			4'd0:    return 8'd0;
			4'd1:    return 8'd18;
			4'd2:    return 8'd95;
			default: return 8'd90;
		endcase
	endfunction

	function automatic logic [ANG_W-1:0] rst_current(input logic [3:0] ch);
		case (ch)
			4'd0:    return 8'd180;
			4'd1:    return 8'd18;
			4'd2:    return 8'd95;
			default: return 8'd90;
		endcase
	endfunction

	function automatic logic [SPD_W-1:0] rst_speed(input logic [3:0] ch);
		case (ch)
			4'd0, 4'd1, 4'd2: return 10'd360;
			default:          return 10'd180;
		endcase
	endfunction

	function automatic logic [PW_W-1:0] pulse_of(input logic [ANG_W-1:0] a);
		logic [ANG_W+PW_MUL_W-1:0] p;
		p = (ANG_W+PW_MUL_W)'(a) * (ANG_W+PW_MUL_W)'(PW_MUL);
		if (a > ANGLE_MAX)
			return '0;
		return PW_W'(p >> PW_SHIFT) + PW_OFFSET;
	endfunction

endpackage

>>> rtl/core/ssrl_if.sv
interface ssrl_item_if;
	logic                         valid;
	logic                         ready;
	logic                         cmd;
	logic [ssrl_pkg::CH_W-1:0]    channel;
	logic [ssrl_pkg::ANG_W-1:0]   target_angle;
	logic [ssrl_pkg::SPD_W-1:0]   speed;
	logic [ssrl_pkg::NOW_W-1:0]   now_ms;

	modport source (output valid, cmd, channel, target_angle, speed, now_ms, input ready);
	modport sink (input valid, cmd, channel, target_angle, speed, now_ms, output ready);
endinterface

interface ssrl_result_if;
	logic                         valid;
	logic                         ready;
	logic [ssrl_pkg::CH_W-1:0]    out_channel;
	logic [ssrl_pkg::ANG_W-1:0]   angle;
	logic [ssrl_pkg::PW_W-1:0]    pulse_width;

	modport source (output valid, out_channel, angle, pulse_width, input ready);
	modport sink (input valid, out_channel, angle, pulse_width, output ready);
endinterface

interface ssrl_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [ssrl_pkg::CFG_IDX_W-1:0] index;
	logic [ssrl_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

>>> rtl/core/servo_slew_rate_limiter.sv
// Channel   Dir  Handshake      Payload
// item      in   valid/ready    cmd, channel, target_angle, speed, now_ms
// result    out  valid/ready    out_channel, angle, pulse_width
// cfg       in   valid/ready    index, data (min/max angle per channel)
//
// A tick passes through channel record read, clamp and time difference, step product,
// divide by 1000, update and write back; the next request is taken only after that.
// A set request reads and writes back the record; a request for a missing channel is dropped.
// Each request for a present channel makes one read-modify-write of the record memory.
// Reset clears the per-channel valid bits at once; there is no clearing pass.
// A full result register holds the update stage until the result is taken.
module servo_slew_rate_limiter #(
	parameter int NUM_CHANNELS = ssrl_pkg::NUM_CHANNELS_DEF,
	parameter int TIME_BITS    = ssrl_pkg::TIME_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	ssrl_item_if.sink     item,
	ssrl_result_if.source result,
	ssrl_cfg_if.sink      cfg
);

	localparam int ADDR_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
	localparam int REC_W  = TIME_BITS + ssrl_pkg::SPD_W + 2 * ssrl_pkg::ANG_W;

	ssrl_pkg::state_t           state_q;
	ssrl_pkg::state_t           state_d;
	ssrl_pkg::slew_ctl_t        ctl;
	ssrl_pkg::limits_t          lim;

	logic                       accept;
	logic                       in_range;
	logic                       ram_re;
	logic                       ram_we;
	logic                       set_wr;
	logic                       rd_load;
	logic                       upd_go;
	logic                       out_load;
	logic [ADDR_W-1:0]          addr_q;
	logic [NUM_CHANNELS-1:0]    valid_q;
	logic [REC_W-1:0]           ram_rdata;
	logic [REC_W-1:0]           ram_wdata;
	logic [REC_W-1:0]           rec;

	logic                       cmd_q;
	logic [ssrl_pkg::CH_W-1:0]  ch_q;
	logic [ssrl_pkg::ANG_W-1:0] tgt_in_q;
	logic [ssrl_pkg::SPD_W-1:0] spd_in_q;
	logic [TIME_BITS-1:0]       now_q;

	logic [ssrl_pkg::ANG_W-1:0] rec_tgt;
	logic [ssrl_pkg::ANG_W-1:0] rec_cur;
	logic [ssrl_pkg::SPD_W-1:0] rec_spd;
	logic [TIME_BITS-1:0]       rec_time;
	logic [ssrl_pkg::ANG_W-1:0] clamped;
	logic [TIME_BITS-1:0]       dt_raw;
	logic [63:0]                dt_wide;
	logic [ssrl_pkg::DT_W-1:0]  dt_capped;

	logic [ssrl_pkg::ANG_W-1:0] tgt_q;
	logic [ssrl_pkg::ANG_W-1:0] cur_q;
	logic [ssrl_pkg::SPD_W-1:0] spd_q;
	logic [ssrl_pkg::DT_W-1:0]  dt_q;
	logic [ssrl_pkg::ANG_W-1:0] new_angle;

	logic                       out_valid_q;
	logic [ssrl_pkg::CH_W-1:0]  out_ch_q;
	logic [ssrl_pkg::ANG_W-1:0] out_ang_q;

	assign accept   = item.valid && item.ready;
	assign in_range = 5'(item.channel) < 5'(NUM_CHANNELS);
	assign upd_go   = !out_valid_q || result.ready;

	// Sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ssrl_pkg::ST_IDLE;
		else
			state_q <= state_d;
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ssrl_pkg::ST_IDLE: begin
				if (accept && in_range)
					state_d = ssrl_pkg::ST_READ;
			end
			ssrl_pkg::ST_READ: begin
				state_d = (cmd_q == ssrl_pkg::CMD_TICK) ? ssrl_pkg::ST_MUL : ssrl_pkg::ST_IDLE;
			end
			ssrl_pkg::ST_MUL: state_d = ssrl_pkg::ST_QUO;
			ssrl_pkg::ST_QUO: state_d = ssrl_pkg::ST_UPD;
			ssrl_pkg::ST_UPD: begin
				if (upd_go)
					state_d = ssrl_pkg::ST_IDLE;
			end
			default: state_d = ssrl_pkg::ST_IDLE;
		endcase
	end

	// Sequencer outputs
	always_comb begin
		item.ready = 1'b0;
		ram_re     = 1'b0;
		set_wr     = 1'b0;
		rd_load    = 1'b0;
		ctl        = '0;
		out_load   = 1'b0;
		unique case (state_q)
			ssrl_pkg::ST_IDLE: begin
				item.ready = 1'b1;
				ram_re     = item.valid && in_range;
			end
			ssrl_pkg::ST_READ: begin
				set_wr  = cmd_q == ssrl_pkg::CMD_SET;
				rd_load = cmd_q == ssrl_pkg::CMD_TICK;
			end
			ssrl_pkg::ST_MUL: ctl.mul_en = 1'b1;
			ssrl_pkg::ST_QUO: ctl.quo_en = 1'b1;
			ssrl_pkg::ST_UPD: out_load = upd_go;
			default: ;
		endcase
	end

	assign ram_we = set_wr || out_load;

	// Capture the request
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q    <= item.cmd;
			ch_q     <= item.channel;
			addr_q   <= ADDR_W'(item.channel);
			tgt_in_q <= item.target_angle;
			spd_in_q <= item.speed;
			now_q    <= TIME_BITS'(item.now_ms);
		end
	end

	// Channel record memory: target, current angle, speed, last tick time
	ssrl_ram #(
		.WIDTH (REC_W),
		.DEPTH (NUM_CHANNELS)
	) u_rec_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (addr_q),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ADDR_W'(item.channel)),
		.rdata (ram_rdata)
	);

	// Mark records written since reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= '0;
		else if (ram_we)
			valid_q[addr_q] <= 1'b1;
	end

	// Substitute reset values for a record never written
	always_comb begin
		if (valid_q[addr_q])
			rec = ram_rdata;
		else
			rec = {ssrl_pkg::rst_target(4'(ch_q)), ssrl_pkg::rst_current(4'(ch_q)),
				ssrl_pkg::rst_speed(4'(ch_q)), TIME_BITS'(0)};
		rec_tgt  = rec[REC_W-1 -: ssrl_pkg::ANG_W];
		rec_cur  = rec[REC_W-ssrl_pkg::ANG_W-1 -: ssrl_pkg::ANG_W];
		rec_spd  = rec[TIME_BITS +: ssrl_pkg::SPD_W];
		rec_time = rec[TIME_BITS-1:0];
	end

	ssrl_cfg #(
		.NUM_CHANNELS (NUM_CHANNELS)
	) u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.ch     (ch_q),
		.lim    (lim)
	);

	// Clamp the target, max test first
	always_comb begin
		if (rec_tgt > lim.max_angle)
			clamped = lim.max_angle;
		else if (rec_tgt < lim.min_angle)
			clamped = lim.min_angle;
		else
			clamped = rec_tgt;
	end

	// Wrap-around time difference, capped
	always_comb begin
		dt_raw    = now_q - rec_time;
		dt_wide   = 64'(dt_raw);
		dt_capped = (dt_wide > 64'(ssrl_pkg::DT_CAP)) ? ssrl_pkg::DT_CAP
			: dt_wide[ssrl_pkg::DT_W-1:0];
	end

	// Hold the tick operands
	always_ff @(posedge clk) begin
		if (rd_load) begin
			tgt_q <= clamped;
			cur_q <= rec_cur;
			spd_q <= rec_spd;
			dt_q  <= dt_capped;
		end
	end

	ssrl_slew u_slew (
		.clk       (clk),
		.ctl       (ctl),
		.speed     (spd_q),
		.dt        (dt_q),
		.cur       (cur_q),
		.tgt       (tgt_q),
		.new_angle (new_angle)
	);

	// Write back: set keeps angle and time, tick stores clamped target and new angle
	always_comb begin
		if (set_wr)
			ram_wdata = {tgt_in_q, rec_cur, spd_in_q, rec_time};
		else
			ram_wdata = {tgt_q, new_angle, spd_q, now_q};
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (out_load)
			out_valid_q <= 1'b1;
		else if (result.ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_ch_q  <= ch_q;
			out_ang_q <= new_angle;
		end
	end

	assign result.valid       = out_valid_q;
	assign result.out_channel = out_ch_q;
	assign result.angle       = out_ang_q;
	assign result.pulse_width = ssrl_pkg::pulse_of(out_ang_q);

endmodule

>>> rtl/core/ssrl_ram.sv
module ssrl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4,
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (re)
			rdata <= mem[raddr];
	end

endmodule

>>> rtl/core/ssrl_cfg.sv
module ssrl_cfg #(
	parameter int NUM_CHANNELS = ssrl_pkg::NUM_CHANNELS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	ssrl_cfg_if.sink                 cfg,
	input  logic [ssrl_pkg::CH_W-1:0] ch,
	output ssrl_pkg::limits_t        lim
);

	logic [ssrl_pkg::ANG_W-1:0] min_q [ssrl_pkg::CFG_CHANNELS];
	logic [ssrl_pkg::ANG_W-1:0] max_q [ssrl_pkg::CFG_CHANNELS];
	logic [ssrl_pkg::CH_W-1:0]  wr_ch;
	logic                       wr_en;

	assign cfg.ready = 1'b1;

	// Decode index: bit 0 picks max over min, bits 2:1 pick the channel, bit 3 must be clear
	assign wr_ch = cfg.index[ssrl_pkg::CH_W:1];
	assign wr_en = cfg.valid && cfg.ready && (cfg.index[ssrl_pkg::CFG_IDX_W-1] == 1'b0)
		&& (5'(wr_ch) < 5'(NUM_CHANNELS));

	// Limit registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ssrl_pkg::CFG_CHANNELS; i++) begin
				min_q[i] <= ssrl_pkg::rst_min(2'(i));
				max_q[i] <= ssrl_pkg::rst_max(2'(i));
			end
		end else if (wr_en) begin
			if (cfg.index[0])
				max_q[wr_ch] <= cfg.data;
			else
				min_q[wr_ch] <= cfg.data;
		end
	end

	// Look up the channel in flight
	assign lim.min_angle = min_q[ch];
	assign lim.max_angle = max_q[ch];

endmodule

>>> rtl/core/ssrl_slew.sv
module ssrl_slew (
	input  logic                       clk,
	input  ssrl_pkg::slew_ctl_t        ctl,
	input  logic [ssrl_pkg::SPD_W-1:0] speed,
	input  logic [ssrl_pkg::DT_W-1:0]  dt,
	input  logic [ssrl_pkg::ANG_W-1:0] cur,
	input  logic [ssrl_pkg::ANG_W-1:0] tgt,
	output logic [ssrl_pkg::ANG_W-1:0] new_angle
);

	localparam int MUL_W = ssrl_pkg::DIVD_W + ssrl_pkg::RECIP_W;

	logic [ssrl_pkg::PROD_W-1:0] prod_q;
	logic [ssrl_pkg::QUO_W-1:0]  quo_q;
	logic                        sat_flo_q;
	logic                        sat_cei_q;
	logic [MUL_W-1:0]            recip_prod;
	logic [ssrl_pkg::DIVD_W-1:0] rem;
	logic                        rem_nz;
	logic [ssrl_pkg::ANG_W-1:0]  step_flo;
	logic [ssrl_pkg::ANG_W-1:0]  step_cei;
	logic [ssrl_pkg::ANG_W:0]    up_sum;
	logic [ssrl_pkg::ANG_W-1:0]  down_gap;

	// Degree-milliseconds moved since the last tick
	always_ff @(posedge clk) begin
		if (ctl.mul_en)
			prod_q <= ssrl_pkg::PROD_W'(speed) * ssrl_pkg::PROD_W'(dt);
	end

	// Divide by 1000 through the reciprocal, flag saturation of both roundings
	assign recip_prod = MUL_W'(prod_q[ssrl_pkg::DIVD_W-1:0]) * MUL_W'(ssrl_pkg::RECIP_1000);

	always_ff @(posedge clk) begin
		if (ctl.quo_en) begin
			quo_q     <= ssrl_pkg::QUO_W'(recip_prod >> ssrl_pkg::RECIP_SHIFT);
			sat_flo_q <= prod_q >= ssrl_pkg::SAT_FLO;
			sat_cei_q <= prod_q > ssrl_pkg::SAT_CEI;
		end
	end

	// Floor and ceiling step, both capped
	always_comb begin
		rem      = prod_q[ssrl_pkg::DIVD_W-1:0]
			- ssrl_pkg::DIVD_W'(ssrl_pkg::DIVD_W'(quo_q) * ssrl_pkg::DIVISOR);
		rem_nz   = rem != '0;
		step_flo = sat_flo_q ? ssrl_pkg::STEP_CAP : quo_q[ssrl_pkg::ANG_W-1:0];
		step_cei = sat_cei_q ? ssrl_pkg::STEP_CAP
			: quo_q[ssrl_pkg::ANG_W-1:0] + ssrl_pkg::ANG_W'(rem_nz);
	end

	// Move toward the target without passing it
	always_comb begin
		up_sum   = {1'b0, cur} + {1'b0, step_flo};
		down_gap = cur - tgt;
		if (cur == tgt)
			new_angle = cur;
		else if (tgt > cur)
			new_angle = (up_sum >= {1'b0, tgt}) ? tgt : up_sum[ssrl_pkg::ANG_W-1:0];
		else if (down_gap <= step_flo || step_cei >= down_gap)
			new_angle = tgt;
		else
			new_angle = cur - step_cei;
	end

endmodule
